/* rtl/rau_pkg.sv */
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;
  localparam int unsigned OpW  = 4;
  localparam int unsigned InW  = 16;
  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 31;
  localparam int unsigned MagW = 33;

  localparam logic [OpW-1:0] OP_ADD = 4'd0;
  localparam logic [OpW-1:0] OP_SUB = 4'd1;
  localparam logic [OpW-1:0] OP_MUL = 4'd2;
  localparam logic [OpW-1:0] OP_DIV = 4'd3;
  localparam logic [OpW-1:0] OP_EQ  = 4'd4;
  localparam logic [OpW-1:0] OP_NE  = 4'd5;
  localparam logic [OpW-1:0] OP_LT  = 4'd6;
  localparam logic [OpW-1:0] OP_LE  = 4'd7;
  localparam logic [OpW-1:0] OP_GT  = 4'd8;
  localparam logic [OpW-1:0] OP_GE  = 4'd9;

  typedef struct packed {
    logic [OpW-1:0]        op;
    logic signed [InW-1:0] a_num;
    logic signed [InW-1:0] a_den;
    logic signed [InW-1:0] b_num;
    logic signed [InW-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [NumW-1:0] res_num;
    logic [DenW-1:0]        res_den;
    logic                   relation_true;
    logic                   error;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture operands, normalise signs
    logic prod1;  // first pair of products
    logic prod2;  // second pair of products
    logic comb;   // combine products, set up gcd
    logic gstep;  // one binary gcd step
    logic dinit;  // start the two divisions by the gcd
    logic dstep;  // one bit of both restoring divisions
    logic fin;    // write result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;   // error or compare: no reduction needed
    logic gdone;   // gcd finished
    logic ddone;   // divisions finished
  } sts_t;
endpackage

/* rtl/rau_if.sv */
// Valid/ready channel carrying one item of type T.
interface rau_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/rau_datapath.sv */
// Datapath: products, binary gcd and bit-serial division by the gcd.
module rau_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rau_pkg::req_t req_i,
  input  rau_pkg::cmd_t cmd_i,
  output rau_pkg::sts_t sts_o,
  output rau_pkg::rsp_t rsp_o
);
  import rau_pkg::*;

  logic [OpW-1:0]        op_q;
  logic signed [16:0]    an_q, ad_q, bn_q, bd_q;
  logic                  err_q;
  logic signed [33:0]    p0_q, p1_q;
  logic signed [33:0]    l_q, r_q;
  logic                  neg_q;
  logic [MagW-1:0]       nm_q, dm_q;
  logic [MagW-1:0]       gx_q, gy_q;
  logic [5:0]            gk_q;
  logic [MagW-1:0]       qn_q, qd_q, rn_q, rd_q;
  logic [5:0]            dcnt_q;
  rsp_t                  rsp_q;

  logic signed [16:0] an_s, ad_s, bn_s, bd_s;
  logic               bad;
  logic signed [34:0] nsum;
  logic signed [33:0] dprod, nsel;
  logic               dneg;
  logic [MagW-1:0]    gdif;
  logic [MagW:0]      rn_sh, rd_sh;
  logic [MagW-1:0]    gdiv;
  logic               rel;

  always_comb begin
    an_s = 17'(req_i.a_num);
    ad_s = 17'(req_i.a_den);
    bn_s = 17'(req_i.b_num);
    bd_s = 17'(req_i.b_den);
    if (ad_s < 0) begin
      an_s = -an_s;
      ad_s = -ad_s;
    end
    if (bd_s < 0) begin
      bn_s = -bn_s;
      bd_s = -bd_s;
    end
    bad = (req_i.op > OP_GE) || (req_i.a_den == '0) || (req_i.b_den == '0)
        || ((req_i.op == OP_DIV) && (req_i.b_num == '0));
  end

  // numerator and denominator before reduction
  always_comb begin
    nsum  = '0;
    dprod = p1_q;
    nsel  = '0;
    case (op_q)
      OP_ADD:  nsum = 35'(l_q) + 35'(r_q);
      OP_SUB:  nsum = 35'(l_q) - 35'(r_q);
      OP_MUL:  begin
        nsum  = 35'(p0_q);
      end
      default: begin
        nsum  = 35'(l_q);
        dprod = r_q;
      end
    endcase
    if (op_q == OP_MUL) dprod = p1_q;
    else if (op_q != OP_DIV) dprod = p1_q;
    dneg = dprod < 0;
    nsel = dneg ? -34'(nsum) : 34'(nsum);
    if (dneg) dprod = -dprod;
  end

  always_comb begin
    gdif = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;
    gdiv = gx_q << gk_q;
    rn_sh = {rn_q, qn_q[MagW-1]};
    rd_sh = {rd_q, qd_q[MagW-1]};
  end

  always_comb begin
    case (op_q)
      OP_EQ:   rel = l_q == r_q;
      OP_NE:   rel = l_q != r_q;
      OP_LT:   rel = l_q < r_q;
      OP_LE:   rel = l_q <= r_q;
      OP_GT:   rel = l_q > r_q;
      default: rel = l_q >= r_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      if (cmd_i.load) err_q <= bad;
      if (cmd_i.fin) begin
        if (err_q) begin
          rsp_q <= '{res_num: '0, res_den: '0, relation_true: 1'b0, error: 1'b1};
        end else if (op_q > OP_DIV) begin
          rsp_q <= '{res_num: '0, res_den: DenW'(1), relation_true: rel, error: 1'b0};
        end else begin
          rsp_q.res_num       <= neg_q ? -NumW'(qn_q) : NumW'(qn_q);
          rsp_q.res_den       <= DenW'(qd_q);
          rsp_q.relation_true <= 1'b0;
          rsp_q.error         <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i.op;
      an_q <= an_s;
      ad_q <= ad_s;
      bn_q <= bn_s;
      bd_q <= bd_s;
    end
    if (cmd_i.prod1) begin
      l_q <= 34'(an_q * bd_q);
      r_q <= 34'(ad_q * bn_q);
    end
    if (cmd_i.prod2) begin
      p0_q <= 34'(an_q * bn_q);
      p1_q <= 34'(ad_q * bd_q);
    end
    if (cmd_i.comb) begin
      neg_q <= nsel < 0;
      nm_q  <= MagW'(nsel < 0 ? -nsel : nsel);
      dm_q  <= MagW'(dprod);
      gx_q  <= MagW'(nsel < 0 ? -nsel : nsel);
      gy_q  <= MagW'(dprod);
      gk_q  <= '0;
    end
    // binary gcd; gx==0 gives gcd=gy
    if (cmd_i.gstep) begin
      if (gx_q == '0) begin
        gx_q <= gy_q;
        gy_q <= '0;
      end else if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1;
        gy_q <= gy_q >> 1;
        gk_q <= gk_q + 6'd1;
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else begin
        gx_q <= (gx_q < gy_q) ? gx_q : gy_q;
        gy_q <= gdif;
      end
    end
    if (cmd_i.dinit) begin
      gx_q   <= gdiv;
      qn_q   <= nm_q;
      qd_q   <= dm_q;
      rn_q   <= '0;
      rd_q   <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.dstep) begin
      dcnt_q <= dcnt_q + 6'd1;
      if (rn_sh >= {1'b0, gx_q}) begin
        rn_q <= MagW'(rn_sh - {1'b0, gx_q});
        qn_q <= {qn_q[MagW-2:0], 1'b1};
      end else begin
        rn_q <= MagW'(rn_sh);
        qn_q <= {qn_q[MagW-2:0], 1'b0};
      end
      if (rd_sh >= {1'b0, gx_q}) begin
        rd_q <= MagW'(rd_sh - {1'b0, gx_q});
        qd_q <= {qd_q[MagW-2:0], 1'b1};
      end else begin
        rd_q <= MagW'(rd_sh);
        qd_q <= {qd_q[MagW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.early = err_q || (op_q > OP_DIV);
  assign sts_o.gdone = (gy_q == '0) && (gx_q != '0);
  assign sts_o.ddone = dcnt_q == 6'(MagW - 1);
  assign rsp_o       = rsp_q;
endmodule

/* rtl/rau_ctrl.sv */
// Controller: sequences operand load, products, gcd and division.
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t cmd_o
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;
  localparam logic [2:0] S_P2   = 3'd2;
  localparam logic [2:0] S_COMB = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DINI = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       fire;

  // output register frees as soon as taken
  assign in_ready_o  = (state_q == S_IDLE);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (fire) begin
          cmd_o.load = 1'b1;
          state_d    = S_P1;
        end
      end
      S_P1: begin
        cmd_o.prod1 = 1'b1;
        state_d     = S_P2;
      end
      S_P2: begin
        cmd_o.prod2 = 1'b1;
        state_d     = sts_i.early ? S_FIN : S_COMB;
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = S_GCD;
      end
      S_GCD: begin
        if (sts_i.gdone) state_d = S_DINI;
        else cmd_o.gstep = 1'b1;
      end
      S_DINI: begin
        cmd_o.dinit = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.dstep = 1'b1;
        if (sts_i.ddone) state_d = S_FIN;
      end
      S_FIN: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          ov_d      = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit.
// One item at a time: an item is taken, its cross-products are formed in S_P1 and S_P2,
// reduced by a binary gcd (one step per cycle) and both parts are then divided by the
// gcd with a shared-control restoring divider. Compares and errors skip reduction and
// go from the products straight to writing the result. The next item is taken while a
// finished result waits in the output register.
module rational_arithmetic_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rau_if.sink   in_i,
  rau_if.source out_o
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rau_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_i.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_o.data)
  );
endmodule
